### rtl/http_header_tokenizer_top_defines.svh
// Shared assertion macros for the header tokenizer.
`ifndef HTTP_HEADER_TOKENIZER_TOP_DEFINES_SVH
`define HTTP_HEADER_TOKENIZER_TOP_DEFINES_SVH

// Clocked assertion, held off while reset is asserted.
`define HHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/hht_pkg.sv
package hht_pkg;

  // Character codes
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Max tokens one byte can produce
  localparam int unsigned MaxTokens = 3;
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    KIND_NAME     = 3'd0,
    KIND_VALUE    = 3'd1,
    KIND_LINE_END = 3'd2,
    KIND_VALID    = 3'd3,
    KIND_INVALID  = 3'd4
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] data;
    tok_kind_e  kind;
  } token_t;

  // All tokens caused by one input byte
  typedef struct packed {
    logic [1:0]                 count;
    token_t [MaxTokens-1:0]     tok;
  } bundle_t;

  // Append one token to a bundle, extra tokens are dropped
  function automatic bundle_t put_token(bundle_t b, logic [7:0] data, tok_kind_e kind);
    bundle_t r;
    r = b;
    if (r.count != 2'd3) begin
      r.tok[r.count].data = data;
      r.tok[r.count].kind = kind;
      r.count = r.count + 2'd1;
    end
    return r;
  endfunction

endpackage

### rtl/http_header_tokenizer_top.sv
// HTTP/1.1 header tokenizer. Message bytes enter one per cycle on the in
// channel; the first line is dropped, header names come out lower case, the
// colon and leading blanks are removed, and each header line ends in a
// line-end token. A blank line yields a "valid" token, a missing colon or an
// early message end an "invalid" token. Each byte yields zero to three
// tokens, flagged by run_end on the last one. The classifier takes a byte
// every cycle while the token queue (QueueDepth entries, one per byte) has
// room; the output side emits one token per cycle while out_ready_i is high,
// so bytes giving at most one token sustain one byte per cycle; others are
// held to the token rate. Tokens pass the queue, then the emitter register.
module http_header_tokenizer_top #(
  parameter int unsigned QueueDepth = hht_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tok_byte_o,
  output logic [2:0] tok_kind_o,
  output logic       run_end_o
);
  import hht_pkg::*;

  logic    push, full, pop, q_valid;
  bundle_t push_data, pop_data;

  // Byte classifier
  hht_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_final_i  (in_final_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Token bundle queue
  hht_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  // Token emitter
  hht_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_byte_o  (tok_byte_o),
    .tok_kind_o  (tok_kind_o),
    .run_end_o   (run_end_o)
  );

endmodule

### rtl/hht_fifo.sv
module hht_fifo #(
  parameter int unsigned Depth = hht_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hht_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output hht_pkg::bundle_t pop_data_o
);
  import hht_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t          mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`include "http_header_tokenizer_top_defines.svh"

  `HHT_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "fifo occupancy above depth")
  `HHT_ASSERT(a_ptr_match,
              (wr_ptr_q == rd_ptr_q) |-> (cnt_q == '0 || full_o),
              "fifo pointers disagree with occupancy")

endmodule

### rtl/hht_front.sv
module hht_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_final_i,
  output logic             push_o,
  output hht_pkg::bundle_t push_data_o,
  input  logic             full_i
);
  import hht_pkg::*;

  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_NAME   = 3'd2;
  localparam logic [2:0] PH_BLANKS = 3'd3;
  localparam logic [2:0] PH_VALUE  = 3'd4;

  typedef struct packed {
    logic [2:0] phase;
    logic       cr;
    bundle_t    bnd;
  } work_t;

  // Byte inside a header name
  function automatic work_t name_byte(work_t w, logic [7:0] b);
    work_t      r;
    logic [7:0] c;
    r = w;
    c = b;
    if (b == CH_COLON) begin
      r.phase = PH_BLANKS;
    end else if (b == CH_CR) begin
      r.cr = 1'b1;
    end else begin
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
        c = b + CASE_OFFSET;
      end
      r.bnd = put_token(r.bnd, c, KIND_NAME);
    end
    return r;
  endfunction

  // Byte inside a header value
  function automatic work_t value_byte(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (b == CH_CR) begin
      r.cr = 1'b1;
    end else begin
      r.bnd = put_token(r.bnd, b, KIND_VALUE);
    end
    return r;
  endfunction

  logic [2:0] phase_q;
  logic       cr_q;
  logic       finished_q, finished_d;
  work_t      w;
  logic       accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte and build its token bundle
  always_comb begin
    w.phase    = phase_q;
    w.cr       = cr_q;
    w.bnd      = '0;
    finished_d = finished_q;
    if (!finished_q) begin
      unique case (phase_q)
        PH_START: begin
          if (w.cr) begin
            w.cr = 1'b0;
            if (in_byte_i == CH_LF) begin
              w.bnd      = put_token(w.bnd, 8'h00, KIND_VALID);
              finished_d = 1'b1;
            end else begin
              w.bnd   = put_token(w.bnd, CH_CR, KIND_NAME);
              w.phase = PH_NAME;
              w       = name_byte(w, in_byte_i);
            end
          end else if (in_byte_i == CH_CR) begin
            w.cr = 1'b1;
          end else begin
            w.phase = PH_NAME;
            w       = name_byte(w, in_byte_i);
          end
        end
        PH_NAME: begin
          if (w.cr) begin
            w.cr = 1'b0;
            if (in_byte_i == CH_LF) begin
              // line without a colon
              w.bnd      = put_token(w.bnd, 8'h00, KIND_INVALID);
              finished_d = 1'b1;
            end else begin
              w.bnd = put_token(w.bnd, CH_CR, KIND_NAME);
              w     = name_byte(w, in_byte_i);
            end
          end else begin
            w = name_byte(w, in_byte_i);
          end
        end
        PH_BLANKS: begin
          if (in_byte_i != CH_SPACE && in_byte_i != CH_TAB) begin
            w.phase = PH_VALUE;
            w       = value_byte(w, in_byte_i);
          end
        end
        PH_VALUE: begin
          if (w.cr) begin
            w.cr = 1'b0;
            if (in_byte_i == CH_LF) begin
              w.bnd   = put_token(w.bnd, 8'h00, KIND_LINE_END);
              w.phase = PH_START;
            end else begin
              w.bnd = put_token(w.bnd, CH_CR, KIND_VALUE);
              w     = value_byte(w, in_byte_i);
            end
          end else begin
            w = value_byte(w, in_byte_i);
          end
        end
        default: begin
          // first line is skipped up to its CRLF
          if (w.cr && in_byte_i == CH_LF) begin
            w.cr    = 1'b0;
            w.phase = PH_START;
          end else begin
            w.cr = (in_byte_i == CH_CR);
          end
        end
      endcase
    end
    // End of message: flag a missing blank line, then start over
    if (in_final_i) begin
      if (!finished_d) begin
        w.bnd = put_token(w.bnd, 8'h00, KIND_INVALID);
      end
      w.phase    = PH_FIRST;
      w.cr       = 1'b0;
      finished_d = 1'b0;
    end
  end

  assign push_o      = accept && (w.bnd.count != 2'd0);
  assign push_data_o = w.bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      cr_q       <= 1'b0;
      finished_q <= 1'b0;
    end else if (accept) begin
      phase_q    <= w.phase;
      cr_q       <= w.cr;
      finished_q <= finished_d;
    end
  end

`include "http_header_tokenizer_top_defines.svh"

  `HHT_ASSERT(a_final_resets,
              (accept && in_final_i) |=> (phase_q == PH_FIRST && !cr_q && !finished_q),
              "message end did not restore parser state")
  `HHT_ASSERT(a_finished_no_cr, finished_q |-> !cr_q, "held CR after header block finished")

endmodule

### rtl/hht_back.sv
module hht_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  hht_pkg::bundle_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       tok_byte_o,
  output logic [2:0]       tok_kind_o,
  output logic             run_end_o
);
  import hht_pkg::*;

  logic       busy_q, busy_d;
  bundle_t    cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       last, take;

  assign last        = (idx_q == cur_q.count - 2'd1);
  assign take        = busy_q && out_ready_i;
  assign q_pop_o     = q_valid_i && (!busy_q || (take && last));
  assign out_valid_o = busy_q;
  assign tok_byte_o  = cur_q.tok[idx_q].data;
  assign tok_kind_o  = cur_q.tok[idx_q].kind;
  assign run_end_o   = last;

  // Step through the tokens of the current bundle
  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    idx_d  = idx_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      cur_d  = q_data_i;
      idx_d  = 2'd0;
    end else if (take && last) begin
      busy_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

`include "http_header_tokenizer_top_defines.svh"

  `HHT_ASSERT(a_bundle_nonempty, q_valid_i |-> (q_data_i.count != 2'd0), "empty bundle queued")
  `HHT_ASSERT(a_run_continues, (take && !last) |=> out_valid_o, "token run broken off before its end")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import hht_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned ItemsPerPhase = 28;

  // Parser position within one message
  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_START  = 3'd1,
    PH_NAME   = 3'd2,
    PH_BLANKS = 3'd3,
    PH_VALUE  = 3'd4
  } hdr_phase_e;

  typedef struct {
    logic [7:0] data;
    tok_kind_e  kind;
    bit         last;
  } tok_exp_t;

  // Predicts the tokens of each accepted byte and checks the token stream
  class token_checker;
    hdr_phase_e parse_phase;
    bit         cr_held;
    bit         msg_done;
    tok_exp_t   byte_tokens[$];
    tok_exp_t   expected_tokens[$];
    int         mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      parse_phase = PH_FIRST;
      cr_held = 1'b0;
      msg_done = 1'b0;
    endfunction

    function void emit(logic [7:0] data, tok_kind_e kind);
      tok_exp_t t;
      t.data = data;
      t.kind = kind;
      t.last = 1'b0;
      if (byte_tokens.size() < MaxTokens) byte_tokens.push_back(t);
    endfunction

    function void name_char(logic [7:0] b);
      if (b == CH_COLON) begin
        parse_phase = PH_BLANKS;
      end else if (b == CH_CR) begin
        cr_held = 1'b1;
      end else begin
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) b = b + CASE_OFFSET;
        emit(b, KIND_NAME);
      end
    endfunction

    function void value_char(logic [7:0] b);
      if (b == CH_CR) cr_held = 1'b1;
      else emit(b, KIND_VALUE);
    endfunction

    // Accepted input transaction: advance the parser and queue its tokens
    function void take_byte(logic [7:0] b, logic fin);
      byte_tokens.delete();
      if (!msg_done) begin
        case (parse_phase)
          PH_START: begin
            if (cr_held) begin
              cr_held = 1'b0;
              if (b == CH_LF) begin
                emit(8'h00, KIND_VALID);
                msg_done = 1'b1;
              end else begin
                emit(CH_CR, KIND_NAME);
                parse_phase = PH_NAME;
                name_char(b);
              end
            end else if (b == CH_CR) begin
              cr_held = 1'b1;
            end else begin
              parse_phase = PH_NAME;
              name_char(b);
            end
          end
          PH_NAME: begin
            if (cr_held) begin
              cr_held = 1'b0;
              if (b == CH_LF) begin
                // header line without a colon
                emit(8'h00, KIND_INVALID);
                msg_done = 1'b1;
              end else begin
                emit(CH_CR, KIND_NAME);
                name_char(b);
              end
            end else begin
              name_char(b);
            end
          end
          PH_BLANKS: begin
            if (b != CH_SPACE && b != CH_TAB) begin
              parse_phase = PH_VALUE;
              value_char(b);
            end
          end
          PH_VALUE: begin
            if (cr_held) begin
              cr_held = 1'b0;
              if (b == CH_LF) begin
                emit(8'h00, KIND_LINE_END);
                parse_phase = PH_START;
              end else begin
                emit(CH_CR, KIND_VALUE);
                value_char(b);
              end
            end else begin
              value_char(b);
            end
          end
          default: begin
            if (cr_held && b == CH_LF) begin
              cr_held = 1'b0;
              parse_phase = PH_START;
            end else begin
              cr_held = (b == CH_CR);
            end
          end
        endcase
      end
      // message end: early end is invalid, held CR is dropped
      if (fin) begin
        if (!msg_done) emit(8'h00, KIND_INVALID);
        restart();
      end
      if (byte_tokens.size() > 0) byte_tokens[$].last = 1'b1;
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endfunction

    // Accepted output transaction: compare with the oldest expected token
    function void check_token(logic [7:0] data, logic [2:0] kind, logic last);
      tok_exp_t e;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token: byte %02h kind %0d run_end %0b",
                 $time, data, kind, last);
        mismatches++;
        return;
      end
      e = expected_tokens.pop_front();
      if (data !== e.data) begin
        $display("%0t: tok_byte mismatch: expected %02h, actual %02h", $time, e.data, data);
        mismatches++;
      end
      if (kind !== e.kind) begin
        $display("%0t: tok_kind mismatch: expected %0d, actual %0d", $time, e.kind, kind);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: run_end mismatch: expected %0b, actual %0b", $time, e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       in_final_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] tok_byte_o;
  logic [2:0] tok_kind_o;
  logic       run_end_o;

  token_checker checker_h = new();
  logic [7:0]   msg_q[$];
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  hold_left;
  int unsigned  quiet_cycles;

  http_header_tokenizer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_final_i (in_final_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .tok_byte_o (tok_byte_o),
    .tok_kind_o (tok_kind_o),
    .run_end_o  (run_end_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) checker_h.take_byte(in_byte_i, in_final_i);
      if (out_valid_o && out_ready_i) checker_h.check_token(tok_byte_o, tok_kind_o, run_end_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("http_header_tokenizer_top verification failed");
        $finish;
      end
    end
  end

  // Token receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Starts and ends at a falling edge; valid stays up until the next call
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_final_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_msg();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  // Name or value content; colon left out of names, CR always left out
  function automatic logic [7:0] text_char(bit no_colon);
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                               : 8'($urandom_range(8'h61, 8'h7A));
    end else begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_CR || (no_colon && c == CH_COLON));
    end
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 4))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_COLON;
      3: return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed messages; some truncated, some plain noise
  task automatic build_msg();
    int unsigned mode;
    int unsigned keep;
    msg_q.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 8)) msg_q.push_back(noise_char());
    end else begin
      repeat ($urandom_range(0, 3)) msg_q.push_back(text_char(1'b0));
      msg_q.push_back(CH_CR);
      msg_q.push_back(CH_LF);
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(0, 4)) begin
          // occasional lone CR inside the name
          if ($urandom_range(0, 9) == 0) msg_q.push_back(CH_CR);
          msg_q.push_back(text_char(1'b1));
        end
        if ($urandom_range(0, 9) != 0) msg_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) msg_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 9) == 0) msg_q.push_back(CH_CR);
          msg_q.push_back(text_char(1'b0));
        end
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
      end
      msg_q.push_back(CH_CR);
      msg_q.push_back(CH_LF);
      repeat ($urandom_range(0, 2)) msg_q.push_back(noise_char());
      if (mode == 1) begin
        keep = $urandom_range(1, msg_q.size());
        while (msg_q.size() > keep) void'(msg_q.pop_back());
      end
    end
  endtask

  initial begin
    int unsigned sent;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = 8'h00;
    in_final_i    = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 29;
    recv_idle_pct = 75;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Upper case, 00/FF, blanks, lone CR in value, empty name and value,
    // blank line, then a body byte ignored after the valid token
    msg_q = '{CH_CR, CH_LF, "A", "z", 8'hFF, CH_COLON, CH_SPACE, CH_TAB, 8'h00, CH_CR, "q",
              CH_CR, CH_LF, CH_COLON, CH_CR, CH_LF, CH_CR, CH_LF, "b"};
    send_msg();
    // header line without a colon
    msg_q = '{CH_CR, CH_LF, "k", CH_CR, CH_LF};
    send_msg();
    // message ends on a held CR
    msg_q = '{CH_CR};
    send_msg();
    // lone CR at line start, then early end: three tokens from one byte
    msg_q = '{CH_CR, CH_LF, CH_CR, "Z"};
    send_msg();

    // Random messages under three idle patterns
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // fill the block while the receiver holds off
          hold_left = HoldCycles;
        end
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        build_msg();
        send_msg();
        sent += msg_q.size();
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then watch for stray tokens
    while (checker_h.expected_tokens.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (checker_h.mismatches == 0) begin
      $display("http_header_tokenizer_top verification clean");
    end else begin
      $display("http_header_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule
